// ===== src/thermostat_average_deadband_core_defines.svh =====
// Assertion macros shared by the checker.
`ifndef THERMOSTAT_AVERAGE_DEADBAND_CORE_DEFINES_SVH
`define THERMOSTAT_AVERAGE_DEADBAND_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define TAD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("thermostat check failed");

// Next-cycle implication.
`define TAD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("thermostat check failed");

`endif

// ===== src/tad_pkg.sv =====
`default_nettype none

package tad_pkg;

    // item kinds
    localparam logic [2:0] KIND_SAMPLE = 3'd0;
    localparam logic [2:0] KIND_UP     = 3'd1;
    localparam logic [2:0] KIND_DOWN   = 3'd2;
    localparam logic [2:0] KIND_TICK   = 3'd3;
    localparam logic [2:0] KIND_POWER  = 3'd4;

    // mode codes on the result
    localparam logic [1:0] MODE_OFF = 2'd0;
    localparam logic [1:0] MODE_ON  = 2'd1;
    localparam logic [1:0] MODE_SET = 2'd2;

    // config register indexes
    localparam logic [1:0] CFG_MIN_SETPOINT    = 2'd0;
    localparam logic [1:0] CFG_MAX_SETPOINT    = 2'd1;
    localparam logic [1:0] CFG_SETTING_TIMEOUT = 2'd2;

    localparam logic [7:0]        STEP = 8'd5;
    localparam logic signed [9:0] BAND = 10'sd5;

    localparam logic [7:0] MIN_SETPOINT_RST    = 8'd35;
    localparam logic [7:0] MAX_SETPOINT_RST    = 8'd75;
    localparam logic [7:0] SETTING_TIMEOUT_RST = 8'd5;

    typedef struct packed {
        logic [7:0] min_setpoint;
        logic [7:0] max_setpoint;
        logic [7:0] setting_timeout;
    } cfg_t;

    typedef struct packed {
        logic [1:0] mode;
        logic       heater_on;
        logic       cooler_on;
        logic       heat_led;
        logic       display_on;
        logic [8:0] display_value;
        logic [7:0] setpoint;
        logic [8:0] average_temp;
    } result_t;

endpackage

`default_nettype wire

// ===== src/tad_avg.sv =====
`default_nettype none

// Sample ring with running sum; mean by reciprocal multiply.
module tad_avg #(
    parameter int NUM_SAMPLES = 10
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       sample_en,
    input  wire logic [9:0] raw_reading,
    output logic      [8:0] mean_now,
    output logic      [8:0] last_now
);

    localparam int IDX_W = $clog2(NUM_SAMPLES);
    localparam int SUM_W = 9 + $clog2(NUM_SAMPLES);
    localparam int K     = SUM_W + $clog2(NUM_SAMPLES);
    localparam int PROD_W = SUM_W + K;
    localparam logic [K-1:0] RECIP = K'((1 << K) / NUM_SAMPLES + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SAMPLES - 1);

    logic [8:0]       ring_reg [NUM_SAMPLES];
    logic             filled_reg;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [8:0]       mean_reg, mean_next;
    logic [8:0]       last_reg;
    logic [8:0]       temp;
    logic [PROD_W-1:0] prod;

    assign temp = raw_reading[9:1];

    always_comb
    begin
        idx_next  = idx_reg;
        sum_next  = sum_reg;
        mean_next = mean_reg;
        prod      = '0;
        if (sample_en)
        begin
            if (!filled_reg)
            begin
                sum_next  = SUM_W'(temp) * SUM_W'(NUM_SAMPLES);
                idx_next  = '0;
                mean_next = temp;
            end
            else
            begin
                sum_next  = sum_reg - SUM_W'(ring_reg[idx_reg]) + SUM_W'(temp);
                idx_next  = (idx_reg == LAST_IDX) ? '0 : idx_reg + 1'b1;
                prod      = PROD_W'(sum_next) * PROD_W'(RECIP);
                mean_next = prod[K+8:K];
            end
        end
    end

    assign mean_now = mean_next;
    assign last_now = sample_en ? temp : last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filled_reg <= 1'b0;
            idx_reg    <= '0;
            sum_reg    <= '0;
            mean_reg   <= '0;
            last_reg   <= '0;
        end
        else if (sample_en)
        begin
            filled_reg <= 1'b1;
            idx_reg    <= idx_next;
            sum_reg    <= sum_next;
            mean_reg   <= mean_next;
            last_reg   <= temp;
        end
    end

    // ring payload, no reset; first sample fills every entry
    always_ff @(posedge clk)
    begin
        if (sample_en)
        begin
            for (int i = 0; i < NUM_SAMPLES; i++)
            begin
                if (!filled_reg || idx_reg == IDX_W'(i))
                begin
                    ring_reg[i] <= temp;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== src/tad_ctrl.sv =====
`default_nettype none

// Mode machine, setpoint, setting timeout and output decode.
module tad_ctrl #(
    parameter int INIT_SETPOINT = 60
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            advance,
    input  wire logic [2:0]      kind,
    input  wire logic            blink_phase,
    input  wire tad_pkg::cfg_t   cfg,
    input  wire logic [8:0]      mean_now,
    input  wire logic [8:0]      last_now,
    output tad_pkg::result_t     result
);

    typedef enum logic [1:0] {
        ST_OFF = tad_pkg::MODE_OFF,
        ST_ON  = tad_pkg::MODE_ON,
        ST_SET = tad_pkg::MODE_SET
    } state_t;

    state_t            state_reg, state_next;
    logic [7:0]        desired_reg, desired_next;
    logic [7:0]        idle_reg, idle_next;
    logic              changed;
    logic [8:0]        bump;
    logic signed [9:0] diff;

    always_comb
    begin
        state_next   = state_reg;
        desired_next = desired_reg;
        idle_next    = idle_reg;
        changed      = 1'b0;
        bump         = {1'b0, desired_reg} + {1'b0, tad_pkg::STEP};
        case (kind)
            tad_pkg::KIND_UP, tad_pkg::KIND_DOWN:
            begin
                if (state_reg == ST_ON)
                begin
                    state_next = ST_SET;
                    idle_next  = '0;
                end
                else if (state_reg == ST_SET)
                begin
                    idle_next = '0;
                    if (kind == tad_pkg::KIND_UP && desired_reg < cfg.max_setpoint)
                    begin
                        desired_next = bump[8] ? 8'hFF : bump[7:0];
                        changed      = 1'b1;
                    end
                    else if (kind == tad_pkg::KIND_DOWN && desired_reg > cfg.min_setpoint)
                    begin
                        desired_next = (desired_reg < tad_pkg::STEP) ? '0
                                     : desired_reg - tad_pkg::STEP;
                        changed      = 1'b1;
                    end
                end
            end
            tad_pkg::KIND_TICK:
            begin
                if (state_reg == ST_SET)
                begin
                    idle_next = (idle_reg == 8'hFF) ? idle_reg : idle_reg + 8'd1;
                    if (idle_next >= cfg.setting_timeout)
                    begin
                        state_next = ST_ON;
                    end
                end
            end
            tad_pkg::KIND_POWER:
            begin
                state_next = (state_reg inside {ST_ON, ST_SET}) ? ST_OFF : ST_ON;
            end
            default:
            begin
            end
        endcase
    end

    // output decode on the post-item state
    always_comb
    begin
        diff   = $signed({2'b00, desired_next}) - $signed({1'b0, mean_now});
        result = '0;
        result.mode         = state_next;
        result.setpoint     = desired_next;
        result.average_temp = mean_now;
        case (state_next)
            ST_ON:
            begin
                result.display_on    = 1'b1;
                result.display_value = last_now;
                if (diff >= tad_pkg::BAND)
                begin
                    result.heater_on = 1'b1;
                    result.heat_led  = blink_phase;
                end
                else if (diff <= -tad_pkg::BAND)
                begin
                    result.cooler_on = 1'b1;
                    result.heat_led  = 1'b1;
                end
            end
            ST_SET:
            begin
                result.display_on    = blink_phase | changed;
                result.display_value = {1'b0, desired_next};
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_OFF;
            desired_reg <= 8'(INIT_SETPOINT);
            idle_reg    <= '0;
        end
        else if (advance)
        begin
            state_reg   <= state_next;
            desired_reg <= desired_next;
            idle_reg    <= idle_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/thermostat_average_deadband_core.sv =====
// Water-heater thermostat: moving-average temperature with a +-5 deadband.
// Input channel (in_valid/in_ready) carries one event per beat: a sensor
// sample, an up or down press, a timer tick or a power toggle, with the
// raw reading and the current blink phase. Output channel
// (out_valid/out_ready) returns exactly one result beat per input beat:
// mode, heater/cooler/LED drives, display enable and value, setpoint and
// the running mean.
// The input register feeds one pass through the averager and mode decode
// into the result register. Throughput: one beat per cycle unless the
// receiver stalls; the averager keeps a running sum so the mean costs one
// add/subtract and one constant multiply per sample.
// When the receiver stalls, the result register holds and the input
// register still takes one more beat; in_ready drops after that until
// out_ready returns.
// Reset (rst_n, async low): mode off, setpoint INIT_SETPOINT, config
// registers to 35/75/5, sample ring empty (first sample fills it), both
// channels empty. Config writes (cfg_we) take effect at once; write them
// only while no beat is in flight.
`default_nettype none

module thermostat_average_deadband_core #(
    parameter int NUM_SAMPLES   = 10,
    parameter int INIT_SETPOINT = 60
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    // config
    input  wire logic       cfg_we,
    input  wire logic [1:0] cfg_index,
    input  wire logic [7:0] cfg_data,
    // event in
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [2:0] kind,
    input  wire logic [9:0] raw_reading,
    input  wire logic       blink_phase,
    // result out
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic      [1:0] mode,
    output logic            heater_on,
    output logic            cooler_on,
    output logic            heat_led,
    output logic            display_on,
    output logic      [8:0] display_value,
    output logic      [7:0] setpoint,
    output logic      [8:0] average_temp
);

    tad_pkg::cfg_t    cfg_reg;
    tad_pkg::result_t result_next, result_reg;

    logic       stage_valid_reg;
    logic [2:0] kind_reg;
    logic [9:0] raw_reg;
    logic       blink_reg;
    logic       out_valid_reg;
    logic       advance;
    logic       sample_en;
    logic [8:0] mean_now, last_now;

    // stage moves into the result register when that slot is free or draining
    assign advance   = stage_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !stage_valid_reg || advance;
    assign sample_en = advance && (kind_reg == tad_pkg::KIND_SAMPLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_setpoint    <= tad_pkg::MIN_SETPOINT_RST;
            cfg_reg.max_setpoint    <= tad_pkg::MAX_SETPOINT_RST;
            cfg_reg.setting_timeout <= tad_pkg::SETTING_TIMEOUT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tad_pkg::CFG_MIN_SETPOINT:    cfg_reg.min_setpoint    <= cfg_data;
                tad_pkg::CFG_MAX_SETPOINT:    cfg_reg.max_setpoint    <= cfg_data;
                tad_pkg::CFG_SETTING_TIMEOUT: cfg_reg.setting_timeout <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            stage_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            kind_reg  <= kind;
            raw_reg   <= raw_reading;
            blink_reg <= blink_phase;
        end
    end

    tad_avg #(
        .NUM_SAMPLES (NUM_SAMPLES)
    ) u_avg (
        .clk         (clk),
        .rst_n       (rst_n),
        .sample_en   (sample_en),
        .raw_reading (raw_reg),
        .mean_now    (mean_now),
        .last_now    (last_now)
    );

    tad_ctrl #(
        .INIT_SETPOINT (INIT_SETPOINT)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .kind        (kind_reg),
        .blink_phase (blink_reg),
        .cfg         (cfg_reg),
        .mean_now    (mean_now),
        .last_now    (last_now),
        .result      (result_next)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign mode          = result_reg.mode;
    assign heater_on     = result_reg.heater_on;
    assign cooler_on     = result_reg.cooler_on;
    assign heat_led      = result_reg.heat_led;
    assign display_on    = result_reg.display_on;
    assign display_value = result_reg.display_value;
    assign setpoint      = result_reg.setpoint;
    assign average_temp  = result_reg.average_temp;

endmodule

`default_nettype wire

// ===== src/tad_chk.sv =====
`default_nettype none
`include "thermostat_average_deadband_core_defines.svh"

// Port-level checks on the result channel.
module tad_chk (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [1:0] mode,
    input wire logic       heater_on,
    input wire logic       cooler_on,
    input wire logic       heat_led,
    input wire logic       display_on,
    input wire logic [8:0] display_value,
    input wire logic [7:0] setpoint
);

    `TAD_ASSERT_NOW(a_off_quiet, out_valid && mode == tad_pkg::MODE_OFF,
        !heater_on && !cooler_on && !heat_led && !display_on && display_value == 9'd0)

    `TAD_ASSERT_NOW(a_no_fight, out_valid, !(heater_on && cooler_on))

    `TAD_ASSERT_NOW(a_set_shows_setpoint, out_valid && mode == tad_pkg::MODE_SET,
        !display_value[8] && display_value[7:0] == setpoint && !heater_on && !cooler_on && !heat_led)

    `TAD_ASSERT_NEXT(a_out_holds, out_valid && !out_ready, out_valid && $stable(setpoint) && $stable(mode))

endmodule

bind thermostat_average_deadband_core tad_chk u_tad_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .mode          (mode),
    .heater_on     (heater_on),
    .cooler_on     (cooler_on),
    .heat_led      (heat_led),
    .display_on    (display_on),
    .display_value (display_value),
    .setpoint      (setpoint)
);

`default_nettype wire
